// ----- hw/rtl/lsra_pkg.sv -----
`default_nettype none
package lsra_pkg;

   localparam int NUM_REGS_DEF  = 16;
   localparam int POS_WIDTH_DEF = 16;
   localparam int MAX_INTERVALS = 1024;

   localparam int ID_W   = 10;
   localparam int SLOT_W = 10;
   localparam int PHYS_W = 4;
   localparam int IN_POS_W = 16;

   localparam int SLOT_LIMIT_INT = (MAX_INTERVALS - 1 > 1023) ? 1023 : MAX_INTERVALS - 1;
   localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(SLOT_LIMIT_INT);

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

endpackage
`default_nettype wire

// ----- hw/rtl/linear_scan_register_allocator.sv -----
// Linear-scan register allocator.
// Request channel (req_*): one live interval per request, sorted by start.
//   req_tuser[0] restarts the allocator (frees all registers, clears the slot
//   counter) before the interval is handled.
// Response channel (rsp_*): exactly one response per request, in order:
//   the physical register granted, or the spill slot of the new interval, or
//   the id and slot of the interval evicted to make room.
// Timing: after a request is taken, one pass over the register table frees
//   expired entries and tracks both the lowest free register and the eviction
//   candidate, one entry per cycle through the table's read port. The response
//   is written to the output register in the decide state after the pass, once
//   that register is free, and the allocator goes back to idle with it;
//   req_tready is high only while no request is in work.
// The response sits in an output register; a stalled receiver does not block
//   the next request, but its decision waits until the held response is taken.
// Reset (synchronous, active high) frees all registers, clears the slot
//   counter and drops rsp_tvalid. Table contents need no clearing.
`default_nettype none
module linear_scan_register_allocator #(
   parameter int NUM_REGS  = lsra_pkg::NUM_REGS_DEF,
   parameter int POS_WIDTH = lsra_pkg::POS_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // interval_id[9:0], start_pos[25:10], end_pos[41:26], zero pad
   input  wire logic [lsra_pkg::REQ_DATA_W-1:0] req_tdata,
   // restart[0]
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // reg_num[3:0], new_slot[13:4], evicted_id[23:14], evicted_slot[33:24], zero pad
   output logic [lsra_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // new_spilled[0], evicted_valid[1]
   output logic [lsra_pkg::RSP_USER_W-1:0]      rsp_tuser
);

   localparam int IDX_W   = $clog2(NUM_REGS);
   localparam int ENTRY_W = lsra_pkg::ID_W + 2 * POS_WIDTH;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REGS - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [NUM_REGS-1:0]           busy_ff, busy_in;
   logic [lsra_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [lsra_pkg::ID_W-1:0]     id_ff, id_in;
   logic [POS_WIDTH-1:0]          st_ff, st_in, en_ff, en_in;
   logic                          iss_on_ff, iss_on_in;
   logic [IDX_W-1:0]              iss_idx_ff, iss_idx_in;
   logic                          chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic                          free_found_ff, free_found_in;
   logic [IDX_W-1:0]              free_idx_ff, free_idx_in;
   logic                          vic_found_ff, vic_found_in;
   logic [IDX_W-1:0]              vic_idx_ff, vic_idx_in;
   logic [POS_WIDTH-1:0]          vic_end_ff, vic_end_in, vic_start_ff, vic_start_in;
   logic [lsra_pkg::ID_W-1:0]     vic_owner_ff, vic_owner_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lsra_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [lsra_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                          ram_we;
   logic [IDX_W-1:0]              ram_waddr;
   logic [ENTRY_W-1:0]            ram_wdata, ram_rdata;

   logic [POS_WIDTH+lsra_pkg::IN_POS_W-1:0] st_ext, en_ext;
   logic [IDX_W+lsra_pkg::PHYS_W-1:0]       phys_ext;
   logic [lsra_pkg::ID_W-1:0]     rd_owner;
   logic [POS_WIDTH-1:0]          rd_start, rd_end;
   logic                          still_busy;
   logic [IDX_W-1:0]              sel_idx;
   logic [lsra_pkg::SLOT_W-1:0]   slot_next;

   assign st_ext = {{POS_WIDTH{1'b0}}, req_tdata[25:10]};
   assign en_ext = {{POS_WIDTH{1'b0}}, req_tdata[41:26]};

   assign rd_owner = ram_rdata[ENTRY_W-1:2*POS_WIDTH];
   assign rd_start = ram_rdata[2*POS_WIDTH-1:POS_WIDTH];
   assign rd_end   = ram_rdata[POS_WIDTH-1:0];

   assign still_busy = busy_ff[chk_idx_ff] && !(rd_end < st_ff);
   assign sel_idx    = free_found_ff ? free_idx_ff : vic_idx_ff;
   assign phys_ext   = {{lsra_pkg::PHYS_W{1'b0}}, sel_idx};
   assign slot_next  = (slot_ff < lsra_pkg::SLOT_LIMIT) ? slot_ff + 1'b1 : slot_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   lsra_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_REGS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (iss_idx_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      slot_in       = slot_ff;
      id_in         = id_ff;
      st_in         = st_ff;
      en_in         = en_ff;
      iss_on_in     = iss_on_ff;
      iss_idx_in    = iss_idx_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      vic_found_in  = vic_found_ff;
      vic_idx_in    = vic_idx_ff;
      vic_end_in    = vic_end_ff;
      vic_start_in  = vic_start_ff;
      vic_owner_in  = vic_owner_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      ram_we        = 1'b0;
      ram_waddr     = sel_idx;
      ram_wdata     = {id_ff, st_ff, en_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               id_in         = req_tdata[9:0];
               st_in         = st_ext[POS_WIDTH-1:0];
               en_in         = en_ext[POS_WIDTH-1:0];
               if (req_tuser) begin
                  busy_in = '0;
                  slot_in = '0;
               end
               iss_on_in     = 1'b1;
               iss_idx_in    = '0;
               free_found_in = 1'b0;
               vic_found_in  = 1'b0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (iss_on_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = iss_idx_ff;
               if (iss_idx_ff == LAST_IDX) begin
                  iss_on_in = 1'b0;
               end else begin
                  iss_idx_in = iss_idx_ff + 1'b1;
               end
            end
            if (chk_valid_ff) begin
               if (!still_busy) begin
                  busy_in[chk_idx_ff] = 1'b0;
                  if (!free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = chk_idx_ff;
                  end
               end else if (!vic_found_ff || rd_end > vic_end_ff ||
                            (rd_end == vic_end_ff && rd_start >= vic_start_ff)) begin
                  vic_found_in = 1'b1;
                  vic_idx_in   = chk_idx_ff;
                  vic_end_in   = rd_end;
                  vic_start_in = rd_start;
                  vic_owner_in = rd_owner;
               end
               if (chk_idx_ff == LAST_IDX) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (free_found_ff) begin
                  ram_we           = 1'b1;
                  busy_in[sel_idx] = 1'b1;
                  rsp_user_in      = 2'b00;
                  rsp_data_in      = {6'd0, 10'd0, 10'd0, 10'd0, phys_ext[3:0]};
               end else if (vic_end_ff > en_ff) begin
                  ram_we      = 1'b1;
                  slot_in     = slot_next;
                  rsp_user_in = 2'b10;
                  rsp_data_in = {6'd0, slot_ff, vic_owner_ff, 10'd0, phys_ext[3:0]};
               end else begin
                  slot_in     = slot_next;
                  rsp_user_in = 2'b01;
                  rsp_data_in = {6'd0, 10'd0, 10'd0, slot_ff, phys_ext[3:0]};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         busy_ff       <= '0;
         slot_ff       <= '0;
         iss_on_ff     <= 1'b0;
         chk_valid_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         vic_found_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         slot_ff       <= slot_in;
         iss_on_ff     <= iss_on_in;
         chk_valid_ff  <= chk_valid_in;
         free_found_ff <= free_found_in;
         vic_found_ff  <= vic_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      st_ff        <= st_in;
      en_ff        <= en_in;
      iss_idx_ff   <= iss_idx_in;
      chk_idx_ff   <= chk_idx_in;
      free_idx_ff  <= free_idx_in;
      vic_idx_ff   <= vic_idx_in;
      vic_end_ff   <= vic_end_in;
      vic_start_ff <= vic_start_in;
      vic_owner_ff <= vic_owner_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= lsra_pkg::SLOT_LIMIT)
      else $error("slot counter beyond limit");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff[0] && rsp_user_ff[1]))
      else $error("new interval spilled and victim evicted together");

   a_free_is_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && free_found_ff) |-> !busy_ff[free_idx_ff])
      else $error("granted register still busy");

   a_decide_has_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> (free_found_ff || vic_found_ff))
      else $error("no register and no victim after scan");

   a_scan_only: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (state_ff == S_SCAN))
      else $error("table read outside scan");

endmodule
`default_nettype wire

// ----- hw/rtl/lsra_ram.sv -----
`default_nettype none
module lsra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
